>>> hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define SWC_ASSERT_NOW(name, pre, post) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication
`define SWC_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

>>> hdl/swc_pkg.sv
`default_nettype none
package swc_pkg;

    localparam int ZENITH_BINS = 7;
    localparam int POLY_TERMS  = 4;
    localparam int LO_W        = $clog2(ZENITH_BINS);
    localparam int LN2_Q16     = 45426;
    localparam int BIN_K       = 6007898;

    // signed Q7.24 of n / 10^e, rounded to nearest
    function automatic longint q24(input longint n, input int e);
        longint t;
        t = n * 64'sd33554432;
        case (e)
            4: begin
                t = t / 64'sd10000;
            end
            5: begin
                t = t / 64'sd100000;
            end
            6: begin
                t = t / 64'sd1000000;
            end
            7: begin
                t = t / 64'sd10000000;
            end
            8: begin
                t = t / 64'sd100000000;
            end
            default: begin
                t = t / 64'sd1000000000;
            end
        endcase
        return (t + ((n < 0) ? -64'sd1 : 64'sd1)) / 2;
    endfunction

    localparam logic signed [31:0] LEN_ROM [ZENITH_BINS][POLY_TERMS] = '{
        '{32'(q24(-190459, 5)), 32'(q24(784166, 6)), 32'(q24(-979834, 7)),
          32'(q24(413616, 8))},
        '{32'(q24(-149174, 5)), 32'(q24(626015, 6)), 32'(q24(-78051, 6)),
          32'(q24(330978, 8))},
        '{32'(q24(-136292, 5)), 32'(q24(571065, 6)), 32'(q24(-703576, 7)),
          32'(q24(294821, 8))},
        '{32'(q24(-164037, 5)), 32'(q24(638111, 6)), 32'(q24(-733976, 7)),
          32'(q24(283247, 8))},
        '{32'(q24(-14705, 4)), 32'(q24(612931, 6)), 32'(q24(-767032, 7)),
          32'(q24(328061, 8))},
        '{32'(q24(-115645, 5)), 32'(q24(47459, 5)), 32'(q24(-573313, 7)),
          32'(q24(238501, 8))},
        '{32'(q24(-809668, 6)), 32'(q24(404381, 6)), 32'(q24(-598228, 7)),
          32'(q24(309438, 8))}
    };

    localparam logic signed [31:0] WID_ROM [ZENITH_BINS][POLY_TERMS] = '{
        '{32'(q24(-407304, 6)), 32'(q24(178678, 6)), 32'(q24(-231434, 7)),
          32'(q24(113588, 8))},
        '{32'(q24(-869331, 7)), 32'(q24(363275, 7)), 32'(q24(-23061, 7)),
          32'(q24(130217, 9))},
        '{32'(q24(-485086, 6)), 32'(q24(20325, 5)), 32'(q24(-25185, 6)),
          32'(q24(114646, 8))},
        '{32'(q24(-274123, 6)), 32'(q24(115825, 6)), 32'(q24(-133312, 7)),
          32'(q24(616812, 9))},
        '{32'(q24(-570203, 6)), 32'(q24(243562, 6)), 32'(q24(-311984, 7)),
          32'(q24(14157, 7))},
        '{32'(q24(-189972, 6)), 32'(q24(792605, 7)), 32'(q24(-755413, 8)),
          32'(q24(276128, 9))},
        '{32'(q24(-408642, 6)), 32'(q24(193252, 6)), 32'(q24(-265448, 7)),
          32'(q24(128923, 8))}
    };

    localparam logic [11:0] LN_FRAC_TAB [17] = '{
        12'd0, 12'd248, 12'd482, 12'd704, 12'd914, 12'd1114, 12'd1304, 12'd1486,
        12'd1661, 12'd1828, 12'd1989, 12'd2143, 12'd2292, 12'd2436, 12'd2575,
        12'd2709, 12'd2839
    };

    typedef logic signed [31:0] acc_t;

    // per-item data that rides along the polynomial stages
    typedef struct packed {
        logic [LO_W-1:0]    lo;
        logic [15:0]        u;
        logic signed [18:0] x;
        logic [15:0]        len;
        logic [15:0]        wid;
        logic               err;
    } side_t;

    typedef struct packed {
        acc_t len_lo;
        acc_t len_hi;
        acc_t wid_lo;
        acc_t wid_hi;
    } acc4_t;

    // v / 4096, halves away from zero
    function automatic logic signed [63:0] rs12(input logic signed [63:0] v);
        if (v >= 0) begin
            return (v + 64'sd2048) >>> 12;
        end else begin
            return -((-v + 64'sd2048) >>> 12);
        end
    endfunction

endpackage
`default_nettype wire

>>> hdl/swc_horner_step.sv
`default_nettype none
module swc_horner_step #(
    parameter int TERM = 0
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 en,
    input  wire                 in_valid,
    input  swc_pkg::side_t      side_in,
    input  swc_pkg::acc4_t      acc_in,
    output logic                valid_reg,
    output swc_pkg::side_t      side_reg,
    output swc_pkg::acc4_t      acc_reg
);
    import swc_pkg::*;

    logic [LO_W-1:0] hi_bin;
    acc4_t           acc_next;

    function automatic acc_t step(input acc_t a, input logic signed [18:0] x,
                                  input acc_t c);
        logic signed [50:0] pr;
        pr = a * x;
        return 32'(rs12(64'(pr)) + 64'(c));
    endfunction

    assign hi_bin = LO_W'(side_in.lo + LO_W'(1));

    always_comb begin
        acc_next.len_lo = step(acc_in.len_lo, side_in.x, LEN_ROM[side_in.lo][TERM]);
        acc_next.len_hi = step(acc_in.len_hi, side_in.x, LEN_ROM[hi_bin][TERM]);
        acc_next.wid_lo = step(acc_in.wid_lo, side_in.x, WID_ROM[side_in.lo][TERM]);
        acc_next.wid_hi = step(acc_in.wid_hi, side_in.x, WID_ROM[hi_bin][TERM]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= side_in;
            acc_reg  <= acc_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/shape_window_cut_unit.sv
// Shape window cut: one result item per input item.
// Input stream s_*: image size, zenith angle, length and width of one event.
// Result stream m_*: pass flags, size error flag and the expected length
// and width (signed Q4.12, saturated).
// APB port: half window for length at 0x0, for width at 0x4; write only
// while the stream is idle. pready is tied high.
// Throughput: one item per cycle; every stage is a pipeline register, with
// the Horner steps one stage each and the interpolation multiply on its own.
// When m_tready is low with a result waiting, the whole pipeline holds and
// s_tready drops in the same cycle; nothing is lost or repeated.
// Zero image size gives size_error with both flags and both values zero.
// Reset (aresetn low, synchronous) empties the pipeline and clears both
// half windows to zero.
`default_nettype none
module shape_window_cut_unit (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // [31:0] image_size, [46:32] zenith_angle, [62:47] image_length,
    // [78:63] image_width, [79] zero
    input  wire  [79:0] s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // [0] length_pass, [1] width_pass, [2] size_error, [18:3] expected_length,
    // [34:19] expected_width, [39:35] zero
    output logic [39:0] m_tdata,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import swc_pkg::*;

    localparam int NSTEP = POLY_TERMS - 1;

    logic en;

    logic [15:0] len_hw_reg;
    logic [15:0] wid_hw_reg;

    // stage 1
    logic [4:0]  p_next;
    logic [31:0] norm;
    logic [37:0] zprod;
    logic        v1_reg;
    logic [4:0]  p_reg;
    logic [3:0]  idx_reg;
    logic [11:0] rem_reg;
    logic [15:0] pos_reg;
    logic [15:0] len1_reg;
    logic [15:0] wid1_reg;
    logic        err1_reg;

    // stage 2
    logic [3:0]         bin_raw;
    logic [LO_W-1:0]    lo_c;
    logic [16:0]        u_c;
    logic [11:0]        tab0;
    logic [11:0]        tab1;
    logic [7:0]         tdiff;
    logic [20:0]        fprod;
    logic [8:0]         frac_c;
    logic signed [5:0]  pm8;
    logic signed [22:0] pp;
    logic signed [18:0] pterm;
    logic               v2_reg;
    side_t              side2_reg;
    side_t              side2_next;

    // Horner chain
    logic  v_s    [NSTEP+1];
    side_t side_s [NSTEP+1];
    acc4_t acc_s  [NSTEP+1];

    // interpolation
    logic signed [32:0] dl;
    logic signed [32:0] dw;
    logic signed [49:0] pl_c;
    logic signed [49:0] pw_c;
    logic               va_reg;
    logic signed [31:0] l0_reg;
    logic signed [31:0] w0_reg;
    logic signed [49:0] pl_reg;
    logic signed [49:0] pw_reg;
    side_t              sidea_reg;

    logic signed [63:0] el_full;
    logic signed [63:0] ew_full;
    logic               vb_reg;
    logic signed [27:0] el_reg;
    logic signed [27:0] ew_reg;
    side_t              sideb_reg;

    // output
    logic signed [29:0] el_lo;
    logic signed [29:0] el_hi;
    logic signed [29:0] ew_lo;
    logic signed [29:0] ew_hi;
    logic signed [29:0] len_x;
    logic signed [29:0] wid_x;
    logic        lpass_c;
    logic        wpass_c;
    logic [15:0] esat_l;
    logic [15:0] esat_w;
    logic        m_valid_reg;
    logic [39:0] m_data_reg;
    logic [39:0] m_data_next;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // configuration
    assign pready = 1'b1;
    assign prdata = paddr[2] ? {16'd0, wid_hw_reg} : {16'd0, len_hw_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_hw_reg <= 16'd0;
            wid_hw_reg <= 16'd0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) begin
                wid_hw_reg <= pwdata[15:0];
            end else begin
                len_hw_reg <= pwdata[15:0];
            end
        end
    end

    // stage 1: leading one, normalize, bin position
    always_comb begin
        p_next = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (s_tdata[i]) begin
                p_next = 5'(i);
            end
        end
        norm  = s_tdata[31:0] << (5'd31 - p_next);
        zprod = 38'(s_tdata[46:32]) * 38'(BIN_K);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg    <= p_next;
            idx_reg  <= norm[30:27];
            rem_reg  <= norm[26:15];
            pos_reg  <= zprod[37:22];
            len1_reg <= s_tdata[62:47];
            wid1_reg <= s_tdata[78:63];
            err1_reg <= (s_tdata[31:0] == 32'd0);
        end
    end

    // stage 2: ln(size / 256) in Q12, bin and weight
    always_comb begin
        bin_raw = pos_reg[15:12];
        if (bin_raw >= 4'(ZENITH_BINS - 1)) begin
            lo_c = LO_W'(ZENITH_BINS - 2);
        end else begin
            lo_c = bin_raw[LO_W-1:0];
        end
        u_c    = {1'b0, pos_reg} - {5'(lo_c), 12'd0};
        tab0   = LN_FRAC_TAB[{1'b0, idx_reg}];
        tab1   = LN_FRAC_TAB[5'({1'b0, idx_reg} + 5'd1)];
        tdiff  = 8'(tab1 - tab0);
        fprod  = 21'(tdiff) * 21'(rem_reg) + 21'd2048;
        frac_c = fprod[20:12];
        pm8    = $signed({1'b0, p_reg}) - 6'sd8;
        pp     = 23'(pm8) * 23'sd45426;
        if (pp >= 0) begin
            pterm = 19'((pp + 23'sd8) >>> 4);
        end else begin
            pterm = 19'(-((-pp + 23'sd8) >>> 4));
        end
        side2_next.lo  = lo_c;
        side2_next.u   = u_c[15:0];
        side2_next.x   = pterm + $signed({7'd0, 12'(tab0) + 12'(frac_c)});
        side2_next.len = len1_reg;
        side2_next.wid = wid1_reg;
        side2_next.err = err1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side2_reg <= side2_next;
        end
    end

    // Horner: top coefficient seeds the accumulators
    assign v_s[0]           = v2_reg;
    assign side_s[0]        = side2_reg;
    assign acc_s[0].len_lo  = LEN_ROM[side2_reg.lo][POLY_TERMS-1];
    assign acc_s[0].len_hi  = LEN_ROM[LO_W'(side2_reg.lo + LO_W'(1))][POLY_TERMS-1];
    assign acc_s[0].wid_lo  = WID_ROM[side2_reg.lo][POLY_TERMS-1];
    assign acc_s[0].wid_hi  = WID_ROM[LO_W'(side2_reg.lo + LO_W'(1))][POLY_TERMS-1];

    for (genvar j = 0; j < NSTEP; j++) begin : g_horner
        swc_horner_step #(
            .TERM(POLY_TERMS - 2 - j)
        ) u_step (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (v_s[j]),
            .side_in  (side_s[j]),
            .acc_in   (acc_s[j]),
            .valid_reg(v_s[j+1]),
            .side_reg (side_s[j+1]),
            .acc_reg  (acc_s[j+1])
        );
    end

    // interpolation multiply
    always_comb begin
        dl   = 33'(acc_s[NSTEP].len_hi) - 33'(acc_s[NSTEP].len_lo);
        dw   = 33'(acc_s[NSTEP].wid_hi) - 33'(acc_s[NSTEP].wid_lo);
        pl_c = 50'(dl) * $signed({34'd0, side_s[NSTEP].u});
        pw_c = 50'(dw) * $signed({34'd0, side_s[NSTEP].u});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else if (en) begin
            va_reg <= v_s[NSTEP];
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            l0_reg    <= acc_s[NSTEP].len_lo;
            w0_reg    <= acc_s[NSTEP].wid_lo;
            pl_reg    <= pl_c;
            pw_reg    <= pw_c;
            sidea_reg <= side_s[NSTEP];
        end
    end

    // add and round back to Q12
    assign el_full = rs12(64'(l0_reg) + rs12(64'(pl_reg)));
    assign ew_full = rs12(64'(w0_reg) + rs12(64'(pw_reg)));

    always_ff @(posedge aclk) begin
        if (en) begin
            el_reg    <= el_full[27:0];
            ew_reg    <= ew_full[27:0];
            sideb_reg <= sidea_reg;
        end
    end

    // window test on unsaturated values, then saturate
    always_comb begin
        el_lo   = 30'(el_reg) - $signed({14'd0, len_hw_reg});
        el_hi   = 30'(el_reg) + $signed({14'd0, len_hw_reg});
        ew_lo   = 30'(ew_reg) - $signed({14'd0, wid_hw_reg});
        ew_hi   = 30'(ew_reg) + $signed({14'd0, wid_hw_reg});
        len_x   = $signed({14'd0, sideb_reg.len});
        wid_x   = $signed({14'd0, sideb_reg.wid});
        lpass_c = (el_lo <= len_x) && (len_x <= el_hi);
        wpass_c = (ew_lo <= wid_x) && (wid_x <= ew_hi);
        if (el_reg > 28'sd32767) begin
            esat_l = 16'h7FFF;
        end else if (el_reg < -28'sd32768) begin
            esat_l = 16'h8000;
        end else begin
            esat_l = el_reg[15:0];
        end
        if (ew_reg > 28'sd32767) begin
            esat_w = 16'h7FFF;
        end else if (ew_reg < -28'sd32768) begin
            esat_w = 16'h8000;
        end else begin
            esat_w = ew_reg[15:0];
        end
        if (sideb_reg.err) begin
            m_data_next = {37'd0, 1'b1, 2'b00};
        end else begin
            m_data_next = {5'd0, esat_w, esat_l, 1'b0, wpass_c, lpass_c};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

`include "assert_macros.svh"

    `SWC_ASSERT_NOW(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready)
    `SWC_ASSERT_NOW(a_err_zeroes_result, m_tvalid && m_tdata[2], m_tdata[34:0] == 35'h4)
    `SWC_ASSERT_NEXT(a_len_window_write, psel && penable && pwrite && !paddr[2], len_hw_reg == $past(pwdata[15:0]))

endmodule
`default_nettype wire

>>> test/tb_top.sv
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import swc_pkg::*;

    localparam int unsigned FLUSH_CYCLES = 5 + POLY_TERMS + 4;
    localparam longint unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned N_RANDOM = 1400;
    localparam logic [2:0] ADDR_LEN_WIN = 3'h0;
    localparam logic [2:0] ADDR_WID_WIN = 3'h4;

    typedef struct packed {
        logic [15:0] exp_wid;
        logic [15:0] exp_len;
        logic        size_err;
        logic        wid_ok;
        logic        len_ok;
    } cut_result_t;

    // mirrors the cut arithmetic and keeps the queue of expected results
    class cut_scoreboard;
        cut_result_t pending[$];
        int unsigned errors = 0;
        logic [15:0] len_win = 0;
        logic [15:0] wid_win = 0;

        function longint rnd_shift(longint v, int s);
            longint h;
            h = longint'(1) <<< (s - 1);
            if (v >= 0) return (v + h) >>> s;
            return -((-v + h) >>> s);
        endfunction

        function longint log_size(logic [31:0] raw);
            int p;
            logic [31:0] m;
            int unsigned idx, rem;
            longint part;
            p = 31;
            while (p > 0 && raw[p] == 1'b0) p--;
            m = raw << (31 - p);
            idx = m[30:27];
            rem = m[26:15];
            part = LN_FRAC_TAB[idx] +
                   ((((LN_FRAC_TAB[idx+1] - LN_FRAC_TAB[idx]) * rem) + 2048) >> 12);
            return rnd_shift(longint'(p - 8) * LN2_Q16, 4) + part;
        endfunction

        function longint cubic(bit is_wid, int bin, longint x);
            longint acc;
            acc = is_wid ? WID_ROM[bin][POLY_TERMS-1] : LEN_ROM[bin][POLY_TERMS-1];
            for (int k = POLY_TERMS - 2; k >= 0; k--)
                acc = rnd_shift(acc * x, 12) + (is_wid ? WID_ROM[bin][k] : LEN_ROM[bin][k]);
            return acc;
        endfunction

        function longint interp(bit is_wid, longint x, int bin, longint u);
            longint a, b;
            a = cubic(is_wid, bin, x);
            b = cubic(is_wid, bin + 1, x);
            return rnd_shift(a + rnd_shift((b - a) * u, 12), 12);
        endfunction

        function logic [15:0] sat(longint v);
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return v[15:0];
        endfunction

        function void note_event(logic [79:0] d);
            cut_result_t r;
            longint unsigned pos;
            int bin;
            longint u, x, el, ew, ln, wd;
            r = '0;
            if (d[31:0] == 0) begin
                r.size_err = 1'b1;
            end else begin
                pos = (longint'(d[46:32]) * BIN_K) >> 22;
                bin = int'(pos >> 12);
                if (bin + 1 >= ZENITH_BINS) bin = ZENITH_BINS - 2;
                u = longint'(pos) - longint'(bin) * 4096;
                x = log_size(d[31:0]);
                el = interp(0, x, bin, u);
                ew = interp(1, x, bin, u);
                ln = d[62:47];
                wd = d[78:63];
                r.len_ok = (el - longint'(len_win) <= ln) && (ln <= el + longint'(len_win));
                r.wid_ok = (ew - longint'(wid_win) <= wd) && (wd <= ew + longint'(wid_win));
                r.exp_len = sat(el);
                r.exp_wid = sat(ew);
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [39:0] d);
            cut_result_t e, a;
            a = d[34:0];
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, got %h", $time, a);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.len_ok !== e.len_ok)
                $display("%0t: length_pass exp %b got %b", $time, e.len_ok, a.len_ok);
            if (a.wid_ok !== e.wid_ok)
                $display("%0t: width_pass exp %b got %b", $time, e.wid_ok, a.wid_ok);
            if (a.size_err !== e.size_err)
                $display("%0t: size_error exp %b got %b", $time, e.size_err, a.size_err);
            if (a.exp_len !== e.exp_len)
                $display("%0t: expected_length exp %h got %h", $time, e.exp_len, a.exp_len);
            if (a.exp_wid !== e.exp_wid)
                $display("%0t: expected_width exp %h got %h", $time, e.exp_wid, a.exp_wid);
            if (a !== e || d[39:35] !== 5'b0) errors++;
        endfunction
    endclass

    logic aclk = 0, aresetn = 0;
    logic s_tvalid = 0, m_tready = 0;
    logic [79:0] s_tdata = '0;
    logic s_tready, m_tvalid, pready;
    logic [39:0] m_tdata;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0, prdata;
    cut_scoreboard sb = new();
    bit hold_off = 0;
    longint unsigned cycles = 0;

    shape_window_cut_unit DUT (.*);

    initial forever #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
        if (aresetn && s_tvalid && s_tready) sb.note_event(s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // result side: random stalls, plus a long hold-off on request
    initial begin
        int w;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready <= 0;
                repeat (60) @(negedge aclk);
                hold_off = 0;
            end
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (w > 0) begin
                m_tready <= 0;
                repeat (w - 1) @(negedge aclk);
                @(negedge aclk);
            end
            m_tready <= 1;
        end
    end

    task automatic reg_write(logic [2:0] a, logic [31:0] v);
        @(negedge aclk);
        psel <= 1; pwrite <= 1; paddr <= a; pwdata <= v; penable <= 0;
        @(negedge aclk);
        penable <= 1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (a == ADDR_LEN_WIN) sb.len_win = v[15:0];
        else sb.wid_win = v[15:0];
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (FLUSH_CYCLES) @(posedge aclk);
    endtask

    task automatic send(logic [79:0] d, bit no_gap);
        int w;
        w = no_gap ? 0 : $urandom_range(0, 6);
        @(negedge aclk);
        if (w > 0) begin
            s_tvalid <= 0;
            repeat (w) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic [79:0] pack_event(logic [31:0] sz, logic [14:0] z,
                                               logic [15:0] l, logic [15:0] w);
        return {1'b0, w, l, z, sz};
    endfunction

    function automatic logic [79:0] rand_event();
        logic [31:0] sz;
        logic [14:0] z;
        case ($urandom_range(0, 9))
            0: sz = 0;
            1: sz = $urandom;
            default: sz = $urandom >> $urandom_range(0, 31);
        endcase
        z = ($urandom_range(0, 7) == 0) ? 15'($urandom) : 15'($urandom_range(0, 25736));
        return pack_event(sz, z, 16'($urandom), 16'($urandom));
    endfunction

    task automatic random_phase(int n, bit no_gap);
        for (int i = 0; i < n; i++) send(rand_event(), no_gap);
        @(negedge aclk);
        s_tvalid <= 0;
    endtask

    initial begin
        logic [15:0] lw, ww;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // directed: size extremes, zero size, angle extremes and extrapolation
        send(pack_event(32'd0, 15'd0, 16'hFFFF, 16'hFFFF), 0);
        send(pack_event(32'd1, 15'd0, 16'h0, 16'h0), 0);
        send(pack_event(32'hFFFF_FFFF, 15'd25736, 16'hFFFF, 16'hFFFF), 0);
        send(pack_event(32'h100, 15'd0, 16'h0, 16'h0), 0);
        send(pack_event(32'h8000_0000, 15'h7FFF, 16'h1234, 16'h0800), 0);
        send(pack_event(32'h0001_0000, 15'd17157, 16'h0, 16'h0), 0);
        send(pack_event(32'h0001_8000, 15'd20000, 16'h2000, 16'h0400), 0);
        send(pack_event(32'd0, 15'h7FFF, 16'h0, 16'h0), 0);
        @(negedge aclk);
        s_tvalid <= 0;
        drain();

        reg_write(ADDR_LEN_WIN, 32'h0000_FFFF);
        reg_write(ADDR_WID_WIN, 32'hFFFF_FFFF);
        for (int i = 0; i < 8; i++) send(rand_event(), 0);
        @(negedge aclk);
        s_tvalid <= 0;
        drain();

        // random phases with different windows; one with a long sink hold-off
        for (int ph = 0; ph < 7; ph++) begin
            lw = (ph == 0) ? 16'h0 : 16'($urandom_range(0, 16'h2000));
            ww = (ph == 0) ? 16'h0 : 16'($urandom_range(0, 16'h1000));
            reg_write(ADDR_LEN_WIN, {16'h0, lw});
            reg_write(ADDR_WID_WIN, {16'h0, ww});
            if (ph == 3) hold_off = 1;
            random_phase(N_RANDOM / 7, ph == 3 || ph == 5);
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> filelist.f
+incdir+hdl
hdl/swc_pkg.sv
hdl/swc_horner_step.sv
hdl/shape_window_cut_unit.sv
test/tb_top.sv
